### rtl/core/deq_pkg.sv
// shared types and codes of the double-ended queue
package deq_pkg;

    typedef enum logic [2:0] {
        FUNC_PUSH_BACK  = 3'd0,
        FUNC_PUSH_FRONT = 3'd1,
        FUNC_POP_BACK   = 3'd2,
        FUNC_POP_FRONT  = 3'd3,
        FUNC_QUERY      = 3'd4
    } func_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    // which end word must be refreshed from the slot memory after a pop
    typedef enum logic [1:0] {
        REFRESH_NONE  = 2'd0,
        REFRESH_FRONT = 2'd1,
        REFRESH_BACK  = 2'd2
    } refresh_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_LOAD = 1'b1
    } state_t;

    typedef struct packed {
        logic [2:0]         func;
        logic signed [31:0] push_value;
    } req_item_t;

    typedef struct packed {
        logic signed [31:0] popped_value;
        logic [1:0]         status;
        logic signed [31:0] front_value;
        logic signed [31:0] back_value;
        logic [6:0]         element_count;
    } rsp_item_t;

    typedef struct packed {
        logic accept;
        logic load;
    } cmd_t;

endpackage

### rtl/core/deq_stream_if.sv
// valid/ready channel carrying one payload per transaction
interface deq_stream_if #(
    parameter type payload_t = deq_pkg::req_item_t
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

### rtl/core/deq_ctrl.sv
// controller of the double-ended queue: sequencing and output handshake
module deq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output deq_pkg::cmd_t     cmd
);

    deq_pkg::state_t state_reg;
    deq_pkg::state_t state_next;
    logic            rsp_valid_reg;
    logic            rsp_valid_next;
    logic            out_free;

    assign out_free = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            deq_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = deq_pkg::ST_LOAD;
                end
            end
            deq_pkg::ST_LOAD:
            begin
                if (out_free)
                begin
                    state_next = deq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = deq_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_ready  = (state_reg == deq_pkg::ST_IDLE);
        cmd.accept = (state_reg == deq_pkg::ST_IDLE) && req_valid;
        cmd.load   = (state_reg == deq_pkg::ST_LOAD) && out_free;
    end

    always_comb
    begin
        if (cmd.load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= deq_pkg::ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

### rtl/core/deq_datapath.sv
// datapath of the double-ended queue: slot memory, indices, end words, result register
module deq_datapath #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  deq_pkg::cmd_t      cmd,
    input  deq_pkg::req_item_t req_item,
    output deq_pkg::rsp_item_t rsp_item
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [DATA_WIDTH-1:0] mem [DEPTH];

    logic [AW-1:0]         head_reg;
    logic [AW-1:0]         head_next;
    logic [AW-1:0]         tail_reg;
    logic [AW-1:0]         tail_next;
    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         count_next;
    logic [DATA_WIDTH-1:0] front_reg;
    logic [DATA_WIDTH-1:0] front_next;
    logic [DATA_WIDTH-1:0] back_reg;
    logic [DATA_WIDTH-1:0] back_next;
    logic [DATA_WIDTH-1:0] popped_reg;
    logic [DATA_WIDTH-1:0] popped_next;
    deq_pkg::status_t      status_reg;
    deq_pkg::status_t      status_next;
    deq_pkg::refresh_t     refresh_reg;
    deq_pkg::refresh_t     refresh_next;
    logic [DATA_WIDTH-1:0] rd_data_reg;
    deq_pkg::rsp_item_t    rsp_item_reg;

    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [AW-1:0]         rd_addr;
    logic [DATA_WIDTH-1:0] word;
    logic [63:0]           push_wide;
    logic                  is_full;
    logic                  is_empty;
    logic [DATA_WIDTH-1:0] front_out;
    logic [DATA_WIDTH-1:0] back_out;
    logic [CW+6:0]         count_wide;

    function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] idx);
        return (idx == AW'(DEPTH - 1)) ? '0 : idx + 1'b1;
    endfunction

    function automatic logic [AW-1:0] prev_slot(input logic [AW-1:0] idx);
        return (idx == '0) ? AW'(DEPTH - 1) : idx - 1'b1;
    endfunction

    function automatic logic [31:0] to_field(input logic [DATA_WIDTH-1:0] w);
        logic [63:0] wide;
        wide = 64'(w);
        return wide[31:0];
    endfunction

    assign push_wide = {32'd0, req_item.push_value};
    assign word      = push_wide[DATA_WIDTH-1:0];
    assign is_full   = (count_reg == CW'(DEPTH));
    assign is_empty  = (count_reg == '0);

    always_comb
    begin
        head_next    = head_reg;
        tail_next    = tail_reg;
        count_next   = count_reg;
        front_next   = front_reg;
        back_next    = back_reg;
        popped_next  = '0;
        status_next  = deq_pkg::STATUS_OK;
        refresh_next = deq_pkg::REFRESH_NONE;
        wr_en        = 1'b0;
        wr_addr      = tail_reg;
        rd_addr      = head_reg;
        unique case (req_item.func)
            deq_pkg::FUNC_PUSH_BACK:
            begin
                if (is_full)
                begin
                    status_next = deq_pkg::STATUS_FULL;
                end
                else
                begin
                    wr_en      = 1'b1;
                    wr_addr    = tail_reg;
                    tail_next  = next_slot(tail_reg);
                    count_next = count_reg + 1'b1;
                    back_next  = word;
                    if (is_empty)
                    begin
                        front_next = word;
                    end
                end
            end
            deq_pkg::FUNC_PUSH_FRONT:
            begin
                if (is_full)
                begin
                    status_next = deq_pkg::STATUS_FULL;
                end
                else
                begin
                    wr_en      = 1'b1;
                    wr_addr    = prev_slot(head_reg);
                    head_next  = prev_slot(head_reg);
                    count_next = count_reg + 1'b1;
                    front_next = word;
                    if (is_empty)
                    begin
                        back_next = word;
                    end
                end
            end
            deq_pkg::FUNC_POP_BACK:
            begin
                if (is_empty)
                begin
                    status_next = deq_pkg::STATUS_EMPTY;
                end
                else
                begin
                    popped_next  = back_reg;
                    tail_next    = prev_slot(tail_reg);
                    // new back word sits one slot before the new tail
                    rd_addr      = prev_slot(prev_slot(tail_reg));
                    count_next   = count_reg - 1'b1;
                    refresh_next = deq_pkg::REFRESH_BACK;
                end
            end
            deq_pkg::FUNC_POP_FRONT:
            begin
                if (is_empty)
                begin
                    status_next = deq_pkg::STATUS_EMPTY;
                end
                else
                begin
                    popped_next  = front_reg;
                    head_next    = next_slot(head_reg);
                    rd_addr      = next_slot(head_reg);
                    count_next   = count_reg - 1'b1;
                    refresh_next = deq_pkg::REFRESH_FRONT;
                end
            end
            default:
            begin
                // query and unused codes leave everything alone
                status_next = deq_pkg::STATUS_OK;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && wr_en)
        begin
            mem[wr_addr] <= word;
        end
        if (cmd.accept)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign front_out  = (refresh_reg == deq_pkg::REFRESH_FRONT) ? rd_data_reg : front_reg;
    assign back_out   = (refresh_reg == deq_pkg::REFRESH_BACK) ? rd_data_reg : back_reg;
    assign count_wide = (CW + 7)'(count_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else if (cmd.accept)
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            front_reg   <= front_next;
            back_reg    <= back_next;
            popped_reg  <= popped_next;
            status_reg  <= status_next;
            refresh_reg <= refresh_next;
        end
        else if (cmd.load)
        begin
            front_reg <= front_out;
            back_reg  <= back_out;
        end
        if (cmd.load)
        begin
            rsp_item_reg.popped_value  <= to_field(popped_reg);
            rsp_item_reg.status        <= status_reg;
            rsp_item_reg.front_value   <= is_empty ? '0 : to_field(front_out);
            rsp_item_reg.back_value    <= is_empty ? '0 : to_field(back_out);
            rsp_item_reg.element_count <= count_wide[6:0];
        end
    end

    assign rsp_item = rsp_item_reg;

endmodule

### rtl/core/double_ended_queue.sv
// Bounded double-ended queue of DEPTH words held in a circular slot memory.
// Each request transaction carries one operation (push back, push front, pop back,
// pop front, query) and gives exactly one response transaction with the popped
// word, a status, the front and back words and the element count. A request
// is taken in the idle state, where the indices are updated and the slot memory is
// written or read; the registered read data reaches the response register in
// the load state once the output is free, and the next request is accepted
// after that load, while the earlier response may still be waiting.
// The front and back words are kept in registers; a pop refreshes the exposed
// end with the one memory read of that item.
module double_ended_queue #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    deq_stream_if.sink   req,
    deq_stream_if.source rsp
);

    deq_pkg::cmd_t      cmd;
    deq_pkg::req_item_t req_item;
    deq_pkg::rsp_item_t rsp_item;

    assign req_item    = req.payload;
    assign rsp.payload = rsp_item;

    deq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .cmd       (cmd)
    );

    deq_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .req_item (req_item),
        .rsp_item (rsp_item)
    );

endmodule
